### rtl/sm4_pkg.sv
package sm4_pkg;

  localparam int ROUNDS = 32;
  localparam int RND_W  = $clog2(ROUNDS);

  localparam logic [127:0] FK = {32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  typedef struct packed {
    logic             load;
    logic             key_step;
    logic             prep;
    logic             round;
    logic             finish;
    logic [RND_W-1:0] idx;
  } sm4_cmd_t;

  typedef struct packed {
    logic out_free;
  } sm4_stat_t;

  function automatic logic [31:0] sbox_word(input logic [31:0] x);
    sbox_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [7:0]  base;
    logic [31:0] w;
    base = 8'({i, 2'b00});
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    ck_word = w;
  endfunction

  function automatic logic [31:0] t_enc(input logic [31:0] a);
    logic [31:0] b;
    b = sbox_word(a);
    t_enc = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
            ^ {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] a);
    logic [31:0] b;
    b = sbox_word(a);
    t_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

endpackage

### rtl/sm4_ctrl.sv
module sm4_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                key_wr,
  input  sm4_pkg::sm4_stat_t  stat,
  output logic                in_ready,
  output sm4_pkg::sm4_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_KEYEXP = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_FINISH = 5'b10000
  } sm4_state_t;

  localparam logic [sm4_pkg::RND_W-1:0] LAST = sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1);

  sm4_state_t                  state_r, state_nxt;
  logic [sm4_pkg::RND_W-1:0]   cnt_r, cnt_nxt;
  logic                        key_stale_r, key_stale_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    key_stale_nxt = key_stale_r | key_wr;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.idx       = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = key_stale_r ? ST_KEYEXP : ST_PREP;
        end
      end
      ST_KEYEXP: begin
        cmd.key_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          key_stale_nxt = key_wr;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      key_stale_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      key_stale_r <= key_stale_nxt;
    end
  end

  a_round_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && cnt_r == LAST) |=> state_r == ST_FINISH)
    else $error("last round did not lead to the finish state");

  a_stale_expands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && key_stale_r) |=> state_r == ST_KEYEXP)
    else $error("stale round keys were not expanded before use");

  a_stale_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEYEXP && cnt_r == LAST) |=> key_stale_r == $past(key_wr))
    else $error("key stale flag wrong after expansion");

  a_fresh_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && !key_stale_r) |=> state_r == ST_PREP)
    else $error("fresh round keys were expanded again");

endmodule

### rtl/sm4_dp.sv
module sm4_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sm4_pkg::sm4_cmd_t  cmd,
  input  logic               decrypt,
  input  logic               chain_mode,
  input  logic [127:0]       key,
  input  logic [127:0]       iv,
  input  logic [127:0]       in_block,
  input  logic               in_first,
  input  logic               out_ready,
  output sm4_pkg::sm4_stat_t stat,
  output logic               out_valid,
  output logic [127:0]       out_result
);

  logic [31:0]               rk_mem [sm4_pkg::ROUNDS];
  logic [31:0]               rk_q;
  logic [sm4_pkg::RND_W-1:0] rd_idx, raddr;
  logic [127:0]              x_r, x_nxt;
  logic [127:0]              k_r, k_nxt;
  logic [127:0]              blk_r;
  logic [127:0]              chain_r, chain_nxt;
  logic [127:0]              chain_src;
  logic [127:0]              res;
  logic [127:0]              out_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [31:0]               new_key;
  logic [31:0]               new_word;

  assign rd_idx = cmd.prep ? '0 : cmd.idx + 1'b1;
  assign raddr  = decrypt ? (sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1) - rd_idx) : rd_idx;

  assign new_key  = k_r[127:96] ^ sm4_pkg::t_key(k_r[95:64] ^ k_r[63:32] ^ k_r[31:0]
                    ^ sm4_pkg::ck_word(cmd.idx));
  assign new_word = x_r[127:96] ^ sm4_pkg::t_enc(x_r[95:64] ^ x_r[63:32] ^ x_r[31:0] ^ rk_q);

  assign chain_src = in_first ? iv : chain_r;
  assign res = {x_r[31:0], x_r[63:32], x_r[95:64], x_r[127:96]}
               ^ ((chain_mode && decrypt) ? chain_r : 128'd0);

  always_comb begin
    x_nxt         = x_r;
    k_nxt         = k_r;
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      x_nxt = in_block ^ ((chain_mode && !decrypt) ? chain_src : 128'd0);
      k_nxt = key ^ sm4_pkg::FK;
      if (in_first) begin
        chain_nxt = iv;
      end
    end
    if (cmd.key_step) begin
      k_nxt = {k_r[95:0], new_key};
    end
    if (cmd.round) begin
      x_nxt = {x_r[95:0], new_word};
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (chain_mode) begin
        chain_nxt = decrypt ? blk_r : res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_step) begin
      rk_mem[cmd.idx] <= new_key;
    end
    rk_q <= rk_mem[raddr];
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    k_r <= k_nxt;
    if (cmd.load) begin
      blk_r <= in_block;
    end
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_result    = out_data_r;

endmodule

### rtl/sm4_block_cipher_ecb_cbc_top.sv
// SM4 block cipher in ECB or CBC mode, one 128-bit block per beat.
// The input stream carries a block on in_tdata and a first-of-message flag on
// in_tuser; the result stream returns one 128-bit block for every input beat,
// in order. Key, direction, chaining mode and IV are written over the APB
// port; the user must write them only while the block is idle, as the
// block does not enforce it. A key write takes effect at the next block.
// An input beat is taken only when the cipher core is free.
// The core expands the 32 round keys into a small key store once after
// reset and after any key write, at one key word per cycle, then runs the
// 32 rounds at one round per cycle from that store. The next block is
// accepted no earlier than the cycle in which the result of the last one
// appears in the output register.
// The result sits in an output register; if the receiver stalls, one finished
// block waits there, the next block is still accepted and computed, and the
// core holds that second result until the register frees.
// Reset clears the configuration registers, the chaining value and the
// output valid flag, and marks the round keys for expansion.
module sm4_block_cipher_ecb_cbc_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high [63:0], block_low [127:64]
  input  logic [0:0]   in_tuser,   // first_block [0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_high [63:0], result_low [127:64]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_DECRYPT    = 3'd2,
    REG_CHAIN_MODE = 3'd3,
    REG_IV_HIGH    = 3'd4,
    REG_IV_LOW     = 3'd5
  } sm4_reg_t;

  logic [63:0]        key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic               decrypt_r, chain_mode_r;
  logic               cfg_wr;
  logic               key_wr;
  sm4_reg_t           reg_sel;
  logic [127:0]       result;
  sm4_pkg::sm4_cmd_t  cmd;
  sm4_pkg::sm4_stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = sm4_reg_t'(cfg_paddr[5:3]);
  assign key_wr     = cfg_wr && (reg_sel == REG_KEY_HIGH || reg_sel == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      decrypt_r    <= 1'b0;
      chain_mode_r <= 1'b0;
      iv_high_r    <= '0;
      iv_low_r     <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_KEY_HIGH:   key_high_r   <= cfg_pwdata;
        REG_KEY_LOW:    key_low_r    <= cfg_pwdata;
        REG_DECRYPT:    decrypt_r    <= cfg_pwdata[0];
        REG_CHAIN_MODE: chain_mode_r <= cfg_pwdata[0];
        REG_IV_HIGH:    iv_high_r    <= cfg_pwdata;
        REG_IV_LOW:     iv_low_r     <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_HIGH:   cfg_prdata = key_high_r;
      REG_KEY_LOW:    cfg_prdata = key_low_r;
      REG_DECRYPT:    cfg_prdata = {63'd0, decrypt_r};
      REG_CHAIN_MODE: cfg_prdata = {63'd0, chain_mode_r};
      REG_IV_HIGH:    cfg_prdata = iv_high_r;
      REG_IV_LOW:     cfg_prdata = iv_low_r;
      default:        cfg_prdata = '0;
    endcase
  end

  sm4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .key_wr   (key_wr),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  sm4_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .decrypt    (decrypt_r),
    .chain_mode (chain_mode_r),
    .key        ({key_high_r, key_low_r}),
    .iv         ({iv_high_r, iv_low_r}),
    .in_block   ({in_tdata[63:0], in_tdata[127:64]}),
    .in_first   (in_tuser[0]),
    .out_ready  (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_result (result)
  );

  assign out_tdata = {result[63:0], result[127:64]};

endmodule

### tb/sm4_ecb_cbc_checker.sv
package sm4_tb_pkg;

  typedef enum logic [2:0] {
    REG_KEY_HIGH,
    REG_KEY_LOW,
    REG_DECRYPT,
    REG_CHAIN_MODE,
    REG_IV_HIGH,
    REG_IV_LOW,
    REG_UNUSED_6,
    REG_UNUSED_7
  } sm4_reg_e;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_result_t;

endpackage

module sm4_ecb_cbc_checker
  import sm4_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high [63:0], block_low [127:64]
  input  logic [0:0]   in_tuser,   // first_block [0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // result_high [63:0], result_low [127:64]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           pending,
  output int           mismatches
);

  localparam int NR = sm4_pkg::ROUNDS;

  logic [63:0]  key_high, key_low, iv_high, iv_low;
  logic         decrypt_mode, cbc_mode;
  logic [127:0] chain_value;
  sm4_result_t  pending_results[$];

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    logic [31:0] y;
    for (int j = 0; j < 4; j++) y[8*j +: 8] = sm4_pkg::SBOX[x[8*j +: 8]];
    return y;
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [32*NR-1:0] expand_round_keys(input logic [127:0] key);
    logic [31:0]      k[4];
    logic [31:0]      b, ck;
    logic [32*NR-1:0] rks;
    for (int w = 0; w < 4; w++) k[w] = key[127-32*w -: 32] ^ sm4_pkg::FK[127-32*w -: 32];
    for (int i = 0; i < NR; i++) begin
      for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'((4*i + j) * 7);
      b = sub_word(k[(i+1)%4] ^ k[(i+2)%4] ^ k[(i+3)%4] ^ ck);
      k[i%4] = k[i%4] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
      rks[32*i +: 32] = k[i%4];
    end
    return rks;
  endfunction

  function automatic logic [127:0] sm4_crypt(input logic [127:0] blk,
                                             input logic [32*NR-1:0] rks,
                                             input logic dec);
    logic [31:0] x[4];
    logic [31:0] rk, b;
    for (int w = 0; w < 4; w++) x[w] = blk[127-32*w -: 32];
    for (int i = 0; i < NR; i++) begin
      rk = dec ? rks[32*(NR-1-i) +: 32] : rks[32*i +: 32];
      b = sub_word(x[(i+1)%4] ^ x[(i+2)%4] ^ x[(i+3)%4] ^ rk);
      x[i%4] = x[i%4] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
    end
    return {x[(NR+3)%4], x[(NR+2)%4], x[(NR+1)%4], x[NR%4]};
  endfunction

  always @(posedge clk) begin
    sm4_result_t      want, got;
    logic [127:0]     blk, res;
    logic [32*NR-1:0] rks;
    if (!rst_n) begin
      key_high = '0;
      key_low = '0;
      iv_high = '0;
      iv_low = '0;
      decrypt_mode = 1'b0;
      cbc_mode = 1'b0;
      chain_value = '0;
      pending_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (sm4_reg_e'(cfg_paddr[5:3]))
          REG_KEY_HIGH:   key_high = cfg_pwdata;
          REG_KEY_LOW:    key_low = cfg_pwdata;
          REG_DECRYPT:    decrypt_mode = cfg_pwdata[0];
          REG_CHAIN_MODE: cbc_mode = cfg_pwdata[0];
          REG_IV_HIGH:    iv_high = cfg_pwdata;
          REG_IV_LOW:     iv_low = cfg_pwdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.result_high = out_tdata[63:0];
        got.result_low = out_tdata[127:64];
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: result_high %h, result_low %h",
                 got.result_high, got.result_low);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.result_high !== want.result_high) begin
            $error("result_high: expected %h, got %h", want.result_high, got.result_high);
            mismatches++;
          end
          if (got.result_low !== want.result_low) begin
            $error("result_low: expected %h, got %h", want.result_low, got.result_low);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rks = expand_round_keys({key_high, key_low});
        blk = {in_tdata[63:0], in_tdata[127:64]};
        if (in_tuser[0]) chain_value = {iv_high, iv_low};
        if (!cbc_mode) begin
          res = sm4_crypt(blk, rks, decrypt_mode);
        end else if (!decrypt_mode) begin
          res = sm4_crypt(blk ^ chain_value, rks, 1'b0);
          chain_value = res;
        end else begin
          res = sm4_crypt(blk, rks, 1'b1) ^ chain_value;
          chain_value = blk;
        end
        want.result_high = res[127:64];
        want.result_low = res[63:0];
        pending_results.push_back(want);
      end
    end
    pending = pending_results.size();
  end

endmodule

### tb/tb.sv
module tb;
  import sm4_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_AFTER = 1700;
  localparam int LONG_HOLD = 400;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [5:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;
  int           pending;
  int           mismatches;
  bit           quiet;
  bit           hold_request;

  sm4_block_cipher_ecb_cbc_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sm4_ecb_cbc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_word_or_extreme();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rand_word();
    endcase
  endfunction

  task automatic reg_write(input sm4_reg_e idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic first);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {lo, hi};
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // The receiver stalls in short random bursts, or for one long stretch on request.
  initial begin
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int sent, phase, count, len;
    logic first;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: ECB encryption under the all-zero key.
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    drain();
    reg_write(REG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    reg_write(REG_KEY_LOW, 64'hfedc_ba98_7654_3210);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
    drain();
    // Only bit 0 of the direction and mode registers counts.
    reg_write(REG_DECRYPT, 64'hffff_ffff_ffff_fffe);
    reg_write(REG_DECRYPT, 64'h1);
    send_block(64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246, 1'b0);
    drain();
    reg_write(REG_IV_HIGH, '1);
    reg_write(REG_IV_LOW, '0);
    reg_write(REG_CHAIN_MODE, 64'h1);
    send_block(rand_word(), rand_word(), 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);
    send_block(rand_word(), rand_word(), 1'b0);
    drain();
    reg_write(REG_DECRYPT, '0);
    send_block(rand_word(), rand_word(), 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);
    send_block(rand_word(), rand_word(), 1'b0);
    drain();
    // ECB with a first beat still reloads the chaining value, which CBC then picks up.
    reg_write(REG_CHAIN_MODE, '0);
    send_block(rand_word(), rand_word(), 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);
    drain();
    reg_write(REG_CHAIN_MODE, 64'h1);
    send_block(rand_word(), rand_word(), 1'b0);
    send_block(rand_word(), rand_word(), 1'b0);
    drain();
    reg_write(REG_UNUSED_6, '1);
    reg_write(REG_UNUSED_7, '1);
    reg_write(REG_KEY_HIGH, '1);
    reg_write(REG_KEY_LOW, '1);
    send_block(rand_word(), rand_word(), 1'b0);
    send_block('0, '1, 1'b0);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      reg_write(REG_KEY_HIGH, rand_word_or_extreme());
      reg_write(REG_KEY_LOW, rand_word_or_extreme());
      reg_write(REG_DECRYPT, rand_word());
      reg_write(REG_CHAIN_MODE, ($urandom_range(0, 3) == 0) ? rand_word() : 64'h1);
      reg_write(REG_IV_HIGH, rand_word_or_extreme());
      reg_write(REG_IV_LOW, rand_word_or_extreme());
      if (phase == 3) hold_request = 1'b1;
      count = 0;
      while (count < $urandom_range(40, 120) && sent < RANDOM_ITEMS) begin
        quiet = (sent >= CALM_AFTER);
        if (phase == 5 && count == 30) drain();
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if (k == 0) first = ($urandom_range(0, 9) != 0);
          else first = ($urandom_range(0, 15) == 0);
          send_block(rand_word(), rand_word(), first);
          count++;
          sent++;
        end
      end
      phase++;
    end

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sm4_pkg.sv
rtl/sm4_ctrl.sv
rtl/sm4_dp.sv
rtl/sm4_block_cipher_ecb_cbc_top.sv
tb/sm4_ecb_cbc_checker.sv
tb/tb.sv
